// File: rtl/pfrd_pkg.sv
`default_nettype none

package pfrd_pkg;

    // operation codes
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_OUTLINE = 2'd1;
    localparam logic [1:0] OP_FILL    = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] left;
        logic [7:0] top;
        logic [7:0] width;
        logic [7:0] height;
        logic [8:0] read_index;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       is_read;
    } t_res;

    // classified request, as queued between front and back
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] right;
        logic [7:0] bottom;
        logic [7:0] cstart;
        logic [7:0] col_lim;
        logic [7:0] row_lim;
        logic [8:0] read_index;
    } t_job;

    // bits lo..hi set
    function automatic logic [7:0] pfrd_byte_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (3'(i) >= lo) && (3'(i) <= hi);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/page_framebuffer_rect_draw.sv
`default_nettype none

// Page-organized 1-bit-per-pixel framebuffer with rectangle drawing.
// Request channel: i_req is taken at a rising edge where start is high and
// busy is low. Operations: clear the store, OR in a rectangle outline, OR in
// a filled rectangle, read one byte back at index page*COLUMNS+column.
// Result channel: every request gives exactly one result, shown on o_res for
// one cycle under o_strobe, in request order; o_res.is_read marks a read.
// There is no back-pressure on results: the receiver must take each one.
// Requests pass a classify stage and a 2-entry queue, so up to two requests
// can wait while the drawing engine works; busy rises when the queue is full.
// The engine works through a single read-modify-write memory port (one
// byte a cycle, reads issued back to back). A read passes S_READ and
// S_RDOUT; a clear writes one byte a cycle; a rectangle takes per side a
// setup step, then visits one byte a cycle, each column stepping its
// pages until the bottom row or the store end.
// Reset: synchronous, active low. After reset a clearing pass zeroes the
// store byte by byte; busy stays high until it is done.

module page_framebuffer_rect_draw
    import pfrd_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_valid;
    logic job_pop;
    logic booting;
    logic req_take;

    // requests held off while the queue is full or the store is being cleared
    assign busy     = queue_full || booting;
    assign req_take = start && !busy;

    pfrd_front u_front (
        .i_req (i_req),
        .o_job (front_job)
    );

    pfrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_take),
        .i_data  (front_job),
        .i_pop   (job_pop),
        .o_data  (queue_job),
        .o_full  (queue_full),
        .o_valid (queue_valid)
    );

    pfrd_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_job_pop   (job_pop),
        .o_booting   (booting),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// File: rtl/pfrd_front.sv
`default_nettype none

module pfrd_front
    import pfrd_pkg::*;
(
    input  t_req i_req,
    output t_job o_job
);

    logic [8:0] sum_xw;
    logic [8:0] sum_yh;
    logic [8:0] xw_m1;
    logic [8:0] yh_m1;
    logic [7:0] fill_col_lim;
    logic [7:0] line_col_lim;

    assign sum_xw = {1'b0, i_req.left} + {1'b0, i_req.width};
    assign sum_yh = {1'b0, i_req.top} + {1'b0, i_req.height};
    assign xw_m1  = sum_xw - 9'd1;
    assign yh_m1  = sum_yh - 9'd1;

    // loop limits clamp to 255
    assign fill_col_lim = sum_xw[8] ? 8'd255 : sum_xw[7:0];

    // x+w-1 below zero draws nothing, same as a limit of zero
    always_comb begin
        if (sum_xw == 9'd0) begin
            line_col_lim = 8'd0;
        end else if (xw_m1[8]) begin
            line_col_lim = 8'd255;
        end else begin
            line_col_lim = xw_m1[7:0];
        end
    end

    always_comb begin
        o_job.op         = i_req.operation;
        o_job.x          = i_req.left;
        o_job.y          = i_req.top;
        o_job.right      = xw_m1[7:0];
        o_job.bottom     = yh_m1[7:0];
        o_job.cstart     = i_req.left + 8'd1;
        o_job.col_lim    = (i_req.operation == OP_OUTLINE) ? line_col_lim : fill_col_lim;
        o_job.row_lim    = sum_yh[8] ? 8'd255 : sum_yh[7:0];
        o_job.read_index = i_req.read_index;
    end

endmodule

`default_nettype wire

// File: rtl/pfrd_queue.sv
`default_nettype none

module pfrd_queue
    import pfrd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_data,
    input  wire  i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_valid
);

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfrd_back.sv
`default_nettype none

module pfrd_back
    import pfrd_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_job i_job,
    input  wire  i_job_valid,
    output logic o_job_pop,
    output logic o_booting,
    output logic o_strobe,
    output t_res o_res
);

    localparam int STORE = COLUMNS * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam int IW    = $clog2(32 * COLUMNS + 512);
    localparam logic [IW-1:0] COL_STEP  = IW'(COLUMNS);
    localparam logic [IW-1:0] STORE_LIM = IW'(STORE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_RDOUT = 3'd6;

    logic [7:0]    mem [STORE];

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic          r_boot;
    logic [AW-1:0] r_clr_cnt;
    logic          r_s1_valid;
    logic          r_strobe;

    t_job          r_job;
    logic [1:0]    r_seg;
    logic [8:0]    r_col;
    logic [8:0]    r_ce;
    logic [4:0]    r_page;
    logic [4:0]    r_first;
    logic [4:0]    r_last;
    logic [2:0]    r_lo;
    logic [2:0]    r_hi;
    logic [IW-1:0] r_base;
    logic [IW-1:0] r_idx;
    logic [AW-1:0] r_s1_idx;
    logic [7:0]    r_s1_mask;
    logic [7:0]    r_rd;
    logic          r_rd_ok;
    t_res          r_res;

    // current segment: columns [seg_cs, seg_ce), rows [seg_rs, seg_re)
    logic [7:0]    seg_cs;
    logic [8:0]    seg_ce;
    logic [7:0]    seg_rs;
    logic [8:0]    seg_re;
    logic [8:0]    seg_rl;
    logic          seg_empty;
    logic          seg_last;

    logic          in_store;
    logic          col_adv;
    logic [8:0]    col_next;
    logic          seg_done;
    logic [7:0]    walk_mask;
    logic [IW-1:0] ri_ext;
    logic          ri_ok;
    logic          clr_last;
    logic          finish;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_comb begin
        seg_cs = r_job.x;
        seg_ce = {1'b0, r_job.col_lim};
        seg_rs = r_job.y;
        seg_re = {1'b0, r_job.row_lim};
        if (r_job.op == OP_OUTLINE) begin
            case (r_seg)
                2'd0: begin
                    seg_ce = {1'b0, r_job.x} + 9'd1;
                end
                2'd1: begin
                    seg_cs = r_job.right;
                    seg_ce = {1'b0, r_job.right} + 9'd1;
                end
                2'd2: begin
                    seg_cs = r_job.cstart;
                    seg_re = {1'b0, r_job.y} + 9'd1;
                end
                2'd3: begin
                    seg_cs = r_job.cstart;
                    seg_rs = r_job.bottom;
                    seg_re = {1'b0, r_job.bottom} + 9'd1;
                end
                default: begin
                    seg_cs = r_job.x;
                end
            endcase
        end
    end

    assign seg_rl    = seg_re - 9'd1;
    assign seg_empty = (seg_ce <= {1'b0, seg_cs}) || (seg_re <= {1'b0, seg_rs});
    assign seg_last  = (r_job.op != OP_OUTLINE) || (r_seg == 2'd3);

    // walk: pages of a column top down, then the next column
    assign in_store  = r_idx < STORE_LIM;
    assign col_adv   = !in_store || (r_page == r_last);
    assign col_next  = r_col + 9'd1;
    assign seg_done  = col_adv && (col_next == r_ce);
    assign walk_mask = pfrd_byte_mask((r_page == r_first) ? r_lo : 3'd0,
                                      (r_page == r_last)  ? r_hi : 3'd7);

    assign ri_ext   = IW'(r_job.read_index);
    assign ri_ok    = ri_ext < STORE_LIM;
    assign clr_last = (r_clr_cnt == LAST_ADDR);

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_LOAD;
                    endcase
                end
            end
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                if (!seg_empty) begin
                    n_state = S_WALK;
                end else if (seg_last) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (seg_done) begin
                    n_state = seg_last ? S_FIN : S_LOAD;
                end
            end
            S_FIN:   n_state = S_IDLE;
            S_READ:  n_state = S_RDOUT;
            S_RDOUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign finish = ((r_state == S_CLEAR) && clr_last && !r_boot)
                 || ((r_state == S_LOAD) && seg_empty && seg_last)
                 || (r_state == S_FIN)
                 || (r_state == S_RDOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_boot     <= 1'b1;
            r_clr_cnt  <= '0;
            r_s1_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == S_WALK) && in_store;
            r_strobe   <= finish;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= clr_last ? '0 : r_clr_cnt + AW'(1);
                if (clr_last) begin
                    r_boot <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_idx[AW-1:0];
        r_s1_mask <= walk_mask;
        r_res.read_data <= ((r_state == S_RDOUT) && r_rd_ok) ? r_rd : 8'd0;
        r_res.is_read   <= (r_state == S_RDOUT);
        if (o_job_pop) begin
            r_job <= i_job;
            r_seg <= 2'd0;
        end
        if (r_state == S_READ) begin
            r_rd_ok <= ri_ok;
        end
        if ((r_state == S_LOAD) && seg_empty) begin
            r_seg <= r_seg + 2'd1;
        end
        if ((r_state == S_LOAD) && !seg_empty) begin
            r_col   <= {1'b0, seg_cs};
            r_ce    <= seg_ce;
            r_page  <= seg_rs[7:3];
            r_first <= seg_rs[7:3];
            r_last  <= seg_rl[7:3];
            r_lo    <= seg_rs[2:0];
            r_hi    <= seg_rl[2:0];
            r_base  <= IW'(IW'(seg_rs[7:3]) * COL_STEP) + IW'(seg_cs);
            r_idx   <= IW'(IW'(seg_rs[7:3]) * COL_STEP) + IW'(seg_cs);
        end
        if (r_state == S_WALK) begin
            if (seg_done) begin
                r_seg <= r_seg + 2'd1;
            end else if (col_adv) begin
                r_col  <= col_next;
                r_page <= r_first;
                r_base <= r_base + IW'(1);
                r_idx  <= r_base + IW'(1);
            end else begin
                r_page <= r_page + 5'd1;
                r_idx  <= r_idx + COL_STEP;
            end
        end
    end

    // one write port, one registered read port
    assign mem_we    = (r_state == S_CLEAR) || r_s1_valid;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_s1_idx;
    assign mem_wdata = (r_state == S_CLEAR) ? 8'd0 : (r_rd | r_s1_mask);
    assign mem_re    = ((r_state == S_WALK) && in_store) || ((r_state == S_READ) && ri_ok);
    assign mem_raddr = (r_state == S_READ) ? ri_ext[AW-1:0] : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    assign o_booting = r_boot;
    assign o_strobe  = r_strobe;
    assign o_res     = r_res;

endmodule

`default_nettype wire

// File: tb/page_framebuffer_rect_draw_test.sv
`default_nettype none

module page_framebuffer_rect_draw_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfrd_pkg::*;

    // Geometry of the block under test (its default build)
    localparam int COLS           = 128;
    localparam int PAGE_COUNT     = 4;
    localparam int STORE_BYTES    = COLS * PAGE_COUNT;
    localparam int REQ_BITS       = $bits(t_req);
    // Longest quiet spell allowed; a full-screen fill or the clearing pass
    // after reset still leaves wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    // Settling time once the last reply is in
    localparam int TAIL_CYCLES    = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_res o_res;

    // Shadow copy of the pixel store, updated as each request is taken
    logic [7:0] shadow_pixels [STORE_BYTES];
    // Replies still owed by the block, oldest first
    t_res       replies_due [$];
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    // Sender idles at random while set
    bit         gaps_on        = 1'b1;
    // Byte index near the last rectangle, so reads land on drawn pixels
    int         recent_index   = 0;
    t_res       want_reply;

    always #4 i_clk = ~i_clk;

    page_framebuffer_rect_draw #(
        .COLUMNS(COLS),
        .PAGES  (PAGE_COUNT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Loop bounds saturate at 255, so row/column 255 is never hit by a loop
    function automatic int clamp_limit(int v);
        return (v > 255) ? 255 : v;
    endfunction

    // Columns past the page width spill into the next page; anything past
    // the end of the store is simply lost.
    function automatic void set_pixel(int row, int col);
        int idx;
        idx = (row >> 3) * COLS + col;
        if (idx < STORE_BYTES) begin
            shadow_pixels[idx] |= 8'(1 << (row & 7));
        end
    endfunction

    // Applies one request to the shadow store and returns the reply it owes
    function automatic t_res draw_on_shadow(t_req r);
        t_res res;
        int   x, y, w, h;
        int   row_lim, col_lim, right, bottom, cstart;
        res = '0;
        x   = int'(r.left);
        y   = int'(r.top);
        w   = int'(r.width);
        h   = int'(r.height);
        case (r.operation)
            OP_CLEAR: begin
                foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
            end
            OP_OUTLINE: begin
                // Right/bottom edges and the first inner column wrap at 8 bits,
                // the horizontal limit is taken unwrapped (may be negative).
                row_lim = clamp_limit(y + h);
                col_lim = clamp_limit(x + w - 1);
                right   = (x + w - 1) & 255;
                bottom  = (y + h - 1) & 255;
                cstart  = (x + 1) & 255;
                for (int rr = y; rr < row_lim; rr++) begin
                    set_pixel(rr, x);
                    set_pixel(rr, right);
                end
                for (int cc = cstart; cc < col_lim; cc++) begin
                    set_pixel(y, cc);
                    set_pixel(bottom, cc);
                end
            end
            OP_FILL: begin
                row_lim = clamp_limit(y + h);
                col_lim = clamp_limit(x + w);
                for (int cc = x; cc < col_lim; cc++) begin
                    for (int rr = y; rr < row_lim; rr++) begin
                        set_pixel(rr, cc);
                    end
                end
            end
            default: begin
                res.is_read = 1'b1;
                if (int'(r.read_index) < STORE_BYTES) begin
                    res.read_data = shadow_pixels[r.read_index];
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic t_req make_request(input logic [1:0] op, input logic [7:0] x,
                                          input logic [7:0] y, input logic [7:0] w,
                                          input logic [7:0] h, input logic [8:0] idx);
        t_req r;
        r.operation  = op;
        r.left       = x;
        r.top        = y;
        r.width      = w;
        r.height     = h;
        r.read_index = idx;
        return r;
    endfunction

    // Entered and left at a falling edge. start is left high on return so
    // back-to-back requests never see it dropped and raised in one step.
    task automatic issue_request(input t_req r);
        while (gaps_on && $urandom_range(99) < 6) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // taken at this edge: predict in request order
        replies_due.push_back(draw_on_shadow(r));
        @(negedge i_clk);
    endtask

    // Hold off new requests until every reply is back
    task automatic drain_replies();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly small rectangles near the top pages, so that drawing stays
    // visible and cheap; reads half the time aim at the last rectangle.
    task automatic build_random_request(output t_req r);
        int unsigned pick;
        int unsigned size_pick;
        int          row;
        int          col;
        r    = t_req'(REQ_BITS'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 3) begin
            r.operation = OP_CLEAR;
        end else if (pick < 38) begin
            r.operation = OP_READ;
            if ($urandom_range(1)) begin
                r.read_index = 9'(recent_index + $urandom_range(0, 9));
            end
        end else begin
            r.operation = (pick < 70) ? OP_OUTLINE : OP_FILL;
            if ($urandom_range(99) < 70) r.top = 8'($urandom_range(0, 39));
            size_pick = $urandom_range(99);
            if (size_pick < 85) begin
                r.width  = 8'($urandom_range(0, 24));
                r.height = 8'($urandom_range(0, 24));
            end else if (size_pick < 97) begin
                r.width  = 8'($urandom_range(0, 80));
                r.height = 8'($urandom_range(0, 80));
            end
            // otherwise keep the full-range size
            col = $urandom_range(1) ? r.left : ((r.left + r.width + 255) & 255);
            row = $urandom_range(1) ? r.top  : ((r.top + r.height + 255) & 255);
            recent_index = ((row >> 3) * COLS + col) & (STORE_BYTES - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Reply checking: strobe is one cycle wide and cannot be held off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply: read_data=%0h is_read=%0b",
                       o_res.read_data, o_res.is_read);
                mismatch_count++;
            end else begin
                want_reply = replies_due.pop_front();
                if (o_res.read_data !== want_reply.read_data) begin
                    $error("read_data: expected %0h, got %0h",
                           want_reply.read_data, o_res.read_data);
                    mismatch_count++;
                end
                if (o_res.is_read !== want_reply.is_read) begin
                    $error("is_read: expected %0b, got %0b",
                           want_reply.is_read, o_res.is_read);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a request taken nor a reply given
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[page_framebuffer_rect_draw] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Store must read back all zero once the clearing pass is done
    task automatic test_after_reset();
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0));
        issue_request(make_request(OP_READ, 8'hff, 8'hff, 8'hff, 8'hff, 9'd511));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd200));
        drain_replies();
    endtask

    // Largest fill: limits clamp, right half spills over, last page drops
    task automatic test_full_fill();
        issue_request(make_request(OP_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 9'd0));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd127));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd383));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd511));
        issue_request(make_request(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0));
        drain_replies();
    endtask

    // Outline corners wrapping at 8 bits, an empty outline, the largest one
    task automatic test_outline_wrap();
        // right edge wraps to column 0, inner columns start over at 0
        issue_request(make_request(OP_OUTLINE, 8'd255, 8'd3, 8'd2, 8'd3, 9'd0));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd254));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd255));
        // zero size: horizontal limit goes below start, nothing drawn
        issue_request(make_request(OP_OUTLINE, 8'd10, 8'd10, 8'd0, 8'd0, 9'd0));
        issue_request(make_request(OP_OUTLINE, 8'd0, 8'd0, 8'd255, 8'd255, 9'd0));
        drain_replies();
    endtask

    // Column spill into the next page, and pixels past the store end
    task automatic test_spill_and_drop();
        issue_request(make_request(OP_FILL, 8'd126, 8'd0, 8'd4, 8'd2, 9'd0));
        issue_request(make_request(OP_FILL, 8'd250, 8'd24, 8'd5, 8'd8, 9'd0));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd128));
        issue_request(make_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd127));
        drain_replies();
    endtask

    // Long stretch with start held high: no sender gaps at all
    task automatic test_back_to_back();
        t_req r;
        gaps_on = 1'b0;
        repeat (300) begin
            build_random_request(r);
            issue_request(r);
        end
        drain_replies();
        gaps_on = 1'b1;
    endtask

    // Random traffic with sender gaps, pausing now and then until idle
    task automatic test_random_traffic();
        t_req r;
        for (int n = 0; n < 850; n++) begin
            build_random_request(r);
            issue_request(r);
            if (n % 200 == 199) drain_replies();
        end
        drain_replies();
    endtask

    initial begin
        foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_full_fill();
        test_outline_wrap();
        test_spill_and_drop();
        test_back_to_back();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[page_framebuffer_rect_draw] OK");
        end else begin
            $display("[page_framebuffer_rect_draw] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
